[hw/rtl/dhcp_option_parser_unit_macros.svh]
// Assertion macros used by the DHCP option parser checker.
// No dependencies; include by bare file name.
`ifndef DHCP_OPTION_PARSER_UNIT_MACROS_SVH
`define DHCP_OPTION_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define DOP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dhcp option parser assertion failed");

// Next-cycle implication, disabled while in reset
`define DOP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dhcp option parser assertion failed");

`endif

[hw/rtl/dhcpop_pkg.sv]
// Shared types, constants and helpers for the DHCP option parser.
// No dependencies; compile first.
`default_nettype none

package dhcpop_pkg;

	// Default size of the options area in bytes
	localparam int unsigned AREA_BYTES_DEF = 312;

	// Option codes
	localparam logic [7:0] CODE_PAD     = 8'd0;
	localparam logic [7:0] CODE_MASK    = 8'd1;
	localparam logic [7:0] CODE_GATEWAY = 8'd3;
	localparam logic [7:0] CODE_DNS     = 8'd6;
	localparam logic [7:0] CODE_LEASE   = 8'd51;
	localparam logic [7:0] CODE_MSGTYPE = 8'd53;
	localparam logic [7:0] CODE_SERVER  = 8'd54;
	localparam logic [7:0] CODE_END     = 8'd255;

	// Magic cookie bytes, in arrival order
	localparam logic [7:0] COOKIE_B0 = 8'h63;
	localparam logic [7:0] COOKIE_B1 = 8'h82;
	localparam logic [7:0] COOKIE_B2 = 8'h53;
	localparam logic [7:0] COOKIE_B3 = 8'h63;

	typedef enum logic [1:0] {
		PH_COOKIE = 2'd0,
		PH_CODE   = 2'd1,
		PH_LEN    = 2'd2,
		PH_VALUE  = 2'd3
	} phase_t;

	// One input transaction
	typedef struct packed {
		logic [7:0]  opt_byte;
		logic        first_byte;
		logic        last_byte;
		logic [31:0] your_addr;
	} item_t;

	// One result transaction
	typedef struct packed {
		logic [31:0] offered_ip;
		logic [31:0] server_id;
		logic [31:0] subnet_mask;
		logic [31:0] router_addr;
		logic [31:0] dns_addr;
		logic [31:0] lease_seconds;
		logic [7:0]  msg_type;
		logic        valid_res;
	} result_t;

	// Expected cookie byte at a position of the cookie
	function automatic logic [7:0] cookie_byte(input logic [1:0] pos);
		logic [7:0] b;
		unique case (pos)
			2'd0: b = COOKIE_B0;
			2'd1: b = COOKIE_B1;
			2'd2: b = COOKIE_B2;
			2'd3: b = COOKIE_B3;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/dhcpop_in_if.sv]
// Byte stream channel into the DHCP option parser.
// No dependencies.
`default_nettype none

interface dhcpop_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  opt_byte;
	logic        first_byte;
	logic        last_byte;
	logic [31:0] your_addr;

	modport source (output valid, output opt_byte, output first_byte,
		output last_byte, output your_addr, input ready);
	modport sink (input valid, input opt_byte, input first_byte,
		input last_byte, input your_addr, output ready);
endinterface

`default_nettype wire

[hw/rtl/dhcpop_res_if.sv]
// Result channel out of the DHCP option parser.
// No dependencies.
`default_nettype none

interface dhcpop_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] offered_ip;
	logic [31:0] server_id;
	logic [31:0] subnet_mask;
	logic [31:0] router_addr;
	logic [31:0] dns_addr;
	logic [31:0] lease_seconds;
	logic [7:0]  msg_type;
	logic        valid_res;

	modport source (output valid, output offered_ip, output server_id,
		output subnet_mask, output router_addr, output dns_addr,
		output lease_seconds, output msg_type, output valid_res, input ready);
	modport sink (input valid, input offered_ip, input server_id,
		input subnet_mask, input router_addr, input dns_addr,
		input lease_seconds, input msg_type, input valid_res, output ready);
endinterface

`default_nettype wire

[hw/rtl/dhcpop_in_stage.sv]
// Input register of the DHCP option parser: holds one byte transaction.
// Depends on dhcpop_pkg.
`default_nettype none

module dhcpop_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dhcpop_pkg::item_t   in_item,
	input  logic                res_busy,
	output logic                fire,
	output dhcpop_pkg::item_t   item_s1
);
	import dhcpop_pkg::*;

	logic valid_s1;
	logic take;

	// Advance unless a last byte would need the result register while it is full
	assign take     = !(item_s1.last_byte && res_busy);
	assign fire     = valid_s1 && take;
	assign in_ready = !valid_s1 || take;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/dhcpop_core.sv]
// Option walker of the DHCP option parser: parse state, captures, result build.
// Depends on dhcpop_pkg.
`default_nettype none

module dhcpop_core #(
	parameter int unsigned AREA_BYTES = dhcpop_pkg::AREA_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  dhcpop_pkg::item_t     item_s1,
	output logic                  emit,
	output dhcpop_pkg::result_t   result
);
	import dhcpop_pkg::*;

	localparam int unsigned IDX_W = $clog2(AREA_BYTES + 1);
	localparam int unsigned SUM_W = ((IDX_W > 8) ? IDX_W : 8) + 1;
	localparam logic [IDX_W-1:0] AREA_IDX  = IDX_W'(AREA_BYTES);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(AREA_BYTES - 1);
	localparam logic [SUM_W-1:0] AREA_SUM  = SUM_W'(AREA_BYTES);
	localparam logic [IDX_W-1:0] COOKIE_END = IDX_W'(3);

	logic [IDX_W-1:0] idx_q,  c_idx,  n_idx;
	phase_t           phase_q, c_phase, n_phase;
	logic             good_q, c_good, n_good;
	logic             halt_q, c_halt, n_halt;
	logic [7:0]       code_q, c_code, n_code;
	logic [7:0]       len_q,  c_len,  n_len;
	logic [7:0]       cnt_q,  c_cnt,  n_cnt;
	logic [31:0]      shift_q, c_shift, n_shift;
	logic [31:0]      shift_in;
	result_t          held_q, c_held, n_held;
	logic [SUM_W-1:0] reach;
	logic [7:0]       b;
	logic [7:0]       type_byte;

	assign b = item_s1.opt_byte;

	// Start from cleared state on the first byte of a stream
	always_comb begin
		if (item_s1.first_byte) begin
			c_idx   = '0;
			c_phase = PH_COOKIE;
			c_good  = 1'b1;
			c_halt  = 1'b0;
			c_code  = '0;
			c_len   = '0;
			c_cnt   = '0;
			c_shift = '0;
			c_held  = '0;
			c_held.offered_ip = item_s1.your_addr;
		end else begin
			c_idx   = idx_q;
			c_phase = phase_q;
			c_good  = good_q;
			c_halt  = halt_q;
			c_code  = code_q;
			c_len   = len_q;
			c_cnt   = cnt_q;
			c_shift = shift_q;
			c_held  = held_q;
		end
	end

	// Area reach of the option whose length byte this is
	assign reach = SUM_W'(c_idx) + SUM_W'(1) + SUM_W'(b);

	// Value shift after this byte; only the first four value bytes are kept
	assign shift_in = (c_cnt < 8'd4) ? {c_shift[23:0], b} : c_shift;

	// First value byte of a message type option, once its value is complete
	always_comb begin
		unique case (c_len)
			8'd1:    type_byte = shift_in[7:0];
			8'd2:    type_byte = shift_in[15:8];
			8'd3:    type_byte = shift_in[23:16];
			default: type_byte = shift_in[31:24];
		endcase
	end

	// Walk one byte of the area
	always_comb begin
		n_idx   = c_idx;
		n_phase = c_phase;
		n_good  = c_good;
		n_halt  = c_halt;
		n_code  = c_code;
		n_len   = c_len;
		n_cnt   = c_cnt;
		n_shift = c_shift;
		n_held  = c_held;
		if (!c_halt && (c_idx < AREA_IDX)) begin
			n_idx = c_idx + IDX_W'(1);
			unique case (c_phase)
				PH_COOKIE: begin
					if (b != cookie_byte(c_idx[1:0])) begin
						n_good = 1'b0;
						n_halt = 1'b1;
					end else if (c_idx == COOKIE_END) begin
						n_phase = PH_CODE;
					end
				end
				PH_CODE: begin
					priority if (b == CODE_END) begin
						n_halt = 1'b1;
					end else if (b == CODE_PAD) begin
						n_phase = PH_CODE;
					end else if (c_idx == LAST_SLOT) begin
						n_halt = 1'b1;
					end else begin
						n_code  = b;
						n_phase = PH_LEN;
					end
				end
				PH_LEN: begin
					n_len = b;
					if (reach > AREA_SUM) begin
						n_halt = 1'b1;
					end else begin
						n_cnt   = '0;
						n_shift = '0;
						// empty options capture nothing
						n_phase = (b == 8'd0) ? PH_CODE : PH_VALUE;
					end
				end
				PH_VALUE: begin
					n_shift = shift_in;
					n_cnt = c_cnt + 8'd1;
					if (n_cnt == c_len) begin
						n_phase = PH_CODE;
						// commit the completed option
						if (c_code == CODE_MSGTYPE) begin
							n_held.msg_type = type_byte;
						end else if (c_len >= 8'd4) begin
							unique case (c_code)
								CODE_MASK:    n_held.subnet_mask   = n_shift;
								CODE_GATEWAY: n_held.router_addr   = n_shift;
								CODE_DNS:     n_held.dns_addr      = n_shift;
								CODE_LEASE:   n_held.lease_seconds = n_shift;
								CODE_SERVER:  n_held.server_id     = n_shift;
								default:      n_held.server_id     = c_held.server_id;
							endcase
						end
					end
				end
			endcase
		end
		// hold after a result until the next first byte
		if (item_s1.last_byte) begin
			n_halt = 1'b1;
		end
	end

	// Build the result from the updated captures
	always_comb begin
		result = n_held;
		result.valid_res = n_good && (n_phase != PH_COOKIE) && (n_held.msg_type != 8'd0);
	end

	assign emit = fire && item_s1.last_byte;

	// Update parse state per accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			phase_q <= PH_COOKIE;
			good_q  <= 1'b1;
			halt_q  <= 1'b0;
			code_q  <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			shift_q <= '0;
			held_q  <= '0;
		end else if (fire) begin
			idx_q   <= n_idx;
			phase_q <= n_phase;
			good_q  <= n_good;
			halt_q  <= n_halt;
			code_q  <= n_code;
			len_q   <= n_len;
			cnt_q   <= n_cnt;
			shift_q <= n_shift;
			held_q  <= n_held;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/dhcpop_out_stage.sv]
// Result register of the DHCP option parser: holds one result transaction.
// Depends on dhcpop_pkg.
`default_nettype none

module dhcpop_out_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  emit,
	input  dhcpop_pkg::result_t   result,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic                  res_busy,
	output dhcpop_pkg::result_t   result_q
);
	import dhcpop_pkg::*;

	assign res_busy = res_valid && !res_ready;

	// Load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (emit) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	// Capture payload
	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= result;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/dhcp_option_parser_unit.sv]
// Top level of the DHCP option parser: input register, option walker, result register.
// Depends on dhcpop_pkg, dhcpop_in_if, dhcpop_res_if and the dhcpop_* stages.
`default_nettype none

// Streams the DHCP options area one byte per transaction, one byte per cycle
// unless stalled as below. A byte is registered, walked through the
// cookie/code/length/value parser, and on a byte flagged last_byte the result
// is loaded into the result register as the byte leaves the input register, and
// is then presented as one result transaction. Input ready drops only while a last
// byte waits in the input register and the result register still holds an untaken
// result. A byte flagged first_byte clears all captures and latches your_addr.
// After a result the parser ignores bytes until the next first_byte; a later
// last_byte repeats the held result. AREA_BYTES (8..511) sets the options-area limit.
module dhcp_option_parser_unit #(
	parameter int unsigned AREA_BYTES = dhcpop_pkg::AREA_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	dhcpop_in_if.sink    in_ch,
	dhcpop_res_if.source res_ch
);
	import dhcpop_pkg::*;

	item_t   in_item;
	item_t   item_s1;
	result_t result;
	result_t result_q;
	logic    fire;
	logic    emit;
	logic    res_busy;

	assign in_item.opt_byte   = in_ch.opt_byte;
	assign in_item.first_byte = in_ch.first_byte;
	assign in_item.last_byte  = in_ch.last_byte;
	assign in_item.your_addr  = in_ch.your_addr;

	dhcpop_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.in_item  (in_item),
		.res_busy (res_busy),
		.fire     (fire),
		.item_s1  (item_s1)
	);

	dhcpop_core #(
		.AREA_BYTES (AREA_BYTES)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item_s1 (item_s1),
		.emit    (emit),
		.result  (result)
	);

	dhcpop_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.result    (result),
		.res_valid (res_ch.valid),
		.res_ready (res_ch.ready),
		.res_busy  (res_busy),
		.result_q  (result_q)
	);

	assign res_ch.offered_ip    = result_q.offered_ip;
	assign res_ch.server_id     = result_q.server_id;
	assign res_ch.subnet_mask   = result_q.subnet_mask;
	assign res_ch.router_addr   = result_q.router_addr;
	assign res_ch.dns_addr      = result_q.dns_addr;
	assign res_ch.lease_seconds = result_q.lease_seconds;
	assign res_ch.msg_type      = result_q.msg_type;
	assign res_ch.valid_res     = result_q.valid_res;

endmodule

`default_nettype wire

[hw/rtl/dhcpop_checker.sv]
// Port-level checks for the DHCP option parser, bound to its top level.
// Depends on dhcp_option_parser_unit_macros.svh and dhcp_option_parser_unit.
`default_nettype none
`include "dhcp_option_parser_unit_macros.svh"

module dhcpop_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] res_offered_ip,
	input logic [31:0] res_lease_seconds,
	input logic [7:0]  res_msg_type,
	input logic        res_valid_res
);

	// A stalled result transaction holds its payload
	`DOP_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_offered_ip) && $stable(res_lease_seconds) && $stable(res_msg_type) && $stable(res_valid_res))

	// A valid parse always carries a message type
	`DOP_ASSERT_NOW(a_valid_type, clk, arst_n, res_valid && res_valid_res, res_msg_type != 8'd0)

	// The input never stalls while the result register is empty
	`DOP_ASSERT_NOW(a_no_idle_stall, clk, arst_n, !res_valid, in_ready)

	// A fresh result follows an accepted last byte through the input and result registers
	`DOP_ASSERT_NOW(a_res_latency, clk, arst_n, $rose(res_valid), $past(in_valid && in_ready && in_last, 2))

endmodule

bind dhcp_option_parser_unit dhcpop_checker u_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_ch.valid),
	.in_ready          (in_ch.ready),
	.in_last           (in_ch.last_byte),
	.res_valid         (res_ch.valid),
	.res_ready         (res_ch.ready),
	.res_offered_ip    (res_ch.offered_ip),
	.res_lease_seconds (res_ch.lease_seconds),
	.res_msg_type      (res_ch.msg_type),
	.res_valid_res     (res_ch.valid_res)
);

`default_nettype wire
